@@ rtl/tmwf_pkg.sv @@
// Shared types, constants and codes for the touch position median filter.
// No dependencies; every other file imports this package.
package tmwf_pkg;

  localparam int unsigned WORD_W           = 16;
  localparam int unsigned SAMPLE_W         = 13;
  localparam int unsigned SAMPLE_LSB       = 3;
  localparam int unsigned CMD_W            = 8;
  localparam int unsigned WINDOW_DEPTH_DEF = 8;
  localparam int unsigned RANK_TAKE        = 4;
  localparam int unsigned SUM_W            = SAMPLE_W + 2;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [CMD_W-1:0] CMD_X   = 8'h93;
  localparam logic [CMD_W-1:0] CMD_Y   = 8'hD3;
  localparam logic [CMD_W-1:0] CMD_AUX = 8'hE3;

  localparam logic [1:0] PHASE_X = 2'd0;
  localparam logic [1:0] PHASE_Y = 2'd2;

  localparam logic [SAMPLE_W-1:0] MAX_SPREAD_RST = 13'd8;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CMD_W-1:0]    cmd_t;

  typedef enum logic [1:0] {
    OP_X,
    OP_Y,
    OP_SKIP
  } op_t;

  // One classified request as it travels from the front end to the back end
  typedef struct packed {
    op_t     op;
    sample_t sample;
    cmd_t    cmd;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Rank taps of one axis window, plus the end-of-update strobe
  typedef struct packed {
    sample_t          lo;
    sample_t          hi;
    logic [SUM_W-1:0] sum;
    logic             done;
  } rank_t;

  typedef enum logic [1:0] {
    AX_IDLE,
    AX_MERGE,
    AX_COPY
  } ax_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MERGE,
    B_FILTER,
    B_EMIT
  } back_state_t;

endpackage

@@ rtl/tmwf_if.sv @@
// Valid/ready channel interfaces for the touch position median filter.
// Depends on tmwf_pkg for field widths.
interface tmwf_in_if;
  import tmwf_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] rx_word;
  modport source (output valid, output rx_word, input ready);
  modport sink   (input valid, input rx_word, output ready);
endinterface

interface tmwf_out_if;
  import tmwf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    next_command;
  logic [SAMPLE_W-1:0] x_position;
  logic [SAMPLE_W-1:0] y_position;
  modport source (output valid, output next_command, output x_position, output y_position,
                  input ready);
  modport sink   (input valid, input next_command, input x_position, input y_position,
                  output ready);
endinterface

interface tmwf_cfg_if;
  import tmwf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] max_spread;
  modport source (output valid, output max_spread, input ready);
  modport sink   (input valid, input max_spread, output ready);
endinterface

@@ rtl/tmwf_front.sv @@
// Front end: accepts converter words, tracks the four-phase counter and
// classifies each request for the back end. Depends on tmwf_pkg, tmwf_if.
module tmwf_front (
  input  logic                clk,
  input  logic                rst_n,
  tmwf_in_if.sink             in_req,
  input  tmwf_pkg::q_status_t q_status,
  output logic                push,
  output tmwf_pkg::entry_t    push_entry
);
  import tmwf_pkg::*;

  logic [1:0] phase_r;
  logic [1:0] phase_nxt;

  assign in_req.ready = !q_status.full;
  assign push         = in_req.valid && in_req.ready;
  assign phase_nxt    = phase_r + 2'd1;

  always_comb begin
    push_entry.sample = in_req.rx_word[WORD_W-1:SAMPLE_LSB];
    unique case (phase_r)
      PHASE_X: begin
        push_entry.op  = OP_X;
        push_entry.cmd = CMD_Y;
      end
      PHASE_Y: begin
        push_entry.op  = OP_Y;
        push_entry.cmd = CMD_X;
      end
      default: begin
        push_entry.op  = OP_SKIP;
        push_entry.cmd = CMD_AUX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ rtl/tmwf_queue.sv @@
// Short request queue between front end and back end.
// Depends on tmwf_pkg for the entry and status types.
module tmwf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tmwf_pkg::entry_t    push_entry,
  input  logic                pop,
  output tmwf_pkg::entry_t    head,
  output tmwf_pkg::q_status_t status
);
  import tmwf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_nxt;

  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("request popped from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("request queue count beyond its depth");
`endif

endmodule

@@ rtl/tmwf_axis.sv @@
// One axis window: an age line of recent samples and a sorted line, updated
// by a one-entry-per-cycle merge walk. Depends on tmwf_pkg.
module tmwf_axis #(
  parameter int unsigned DEPTH = tmwf_pkg::WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tmwf_pkg::sample_t sample,
  output tmwf_pkg::rank_t   rank
);
  import tmwf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned BASE  = DEPTH / 2 - 2;

  sample_t          age_r    [DEPTH];
  sample_t          sorted_r [DEPTH];
  sample_t          merge_r  [DEPTH];
  sample_t          new_r;
  sample_t          old_r;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] emitted_r;
  logic             removed_r;
  logic             placed_r;
  ax_state_t        state_r;
  ax_state_t        state_nxt;

  sample_t          head;
  sample_t          emit_val;
  logic             src_empty;
  logic             take_old;
  logic             put_new;
  logic             put_head;
  logic             emit;
  logic [SUM_W-1:0] sum;

  assign head      = sorted_r[0];
  assign src_empty = (used_r == CNT_W'(DEPTH));
  assign emit      = put_new || put_head;
  assign emit_val  = put_new ? new_r : head;

  always_comb begin
    state_nxt = state_r;
    take_old  = 1'b0;
    put_new   = 1'b0;
    put_head  = 1'b0;
    unique case (state_r)
      AX_IDLE: begin
        if (start) begin
          state_nxt = AX_MERGE;
        end
      end
      AX_MERGE: begin
        // drop the oldest value once, place the new one before the first >= entry
        priority if (src_empty) begin
          put_new = 1'b1;
        end else if (!removed_r && head == old_r) begin
          take_old = 1'b1;
        end else if (!placed_r && new_r <= head) begin
          put_new = 1'b1;
        end else begin
          put_head = 1'b1;
        end
        if ((put_new || put_head) && emitted_r == CNT_W'(DEPTH - 1)) begin
          state_nxt = AX_COPY;
        end
      end
      AX_COPY: begin
        state_nxt = AX_IDLE;
      end
      default: begin
        state_nxt = AX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= AX_IDLE;
      used_r    <= '0;
      emitted_r <= '0;
      removed_r <= 1'b0;
      placed_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        used_r    <= '0;
        emitted_r <= '0;
        removed_r <= 1'b0;
        placed_r  <= 1'b0;
      end else begin
        if (take_old || put_head) begin
          used_r <= used_r + 1'b1;
        end
        if (emit) begin
          emitted_r <= emitted_r + 1'b1;
        end
        if (take_old) begin
          removed_r <= 1'b1;
        end
        if (put_new) begin
          placed_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        age_r[i]    <= '0;
        sorted_r[i] <= '0;
      end
    end else begin
      if (start) begin
        age_r[0] <= sample;
        for (int i = 1; i < DEPTH; i++) begin
          age_r[i] <= age_r[i-1];
        end
      end
      if (take_old || put_head) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          sorted_r[i] <= sorted_r[i+1];
        end
      end
      if (state_r == AX_COPY) begin
        for (int i = 0; i < DEPTH; i++) begin
          sorted_r[i] <= merge_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      new_r <= sample;
      old_r <= age_r[DEPTH-1];
    end
    if (emit) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        merge_r[i] <= merge_r[i+1];
      end
      merge_r[DEPTH-1] <= emit_val;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < RANK_TAKE; i++) begin
      sum = sum + SUM_W'(sorted_r[BASE + i]);
    end
  end

  assign rank.lo   = sorted_r[BASE];
  assign rank.hi   = sorted_r[BASE + RANK_TAKE - 1];
  assign rank.sum  = sum;
  assign rank.done = (state_r == AX_COPY);

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == AX_IDLE)
    else $error("window update started while a merge is running");

  a_new_placed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == AX_COPY |-> placed_r)
    else $error("merge finished without placing the new sample");

  a_ranks_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == AX_IDLE |-> sorted_r[BASE] <= sorted_r[BASE + RANK_TAKE - 1])
    else $error("sorted window out of order");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == AX_MERGE |-> emitted_r < CNT_W'(DEPTH))
    else $error("merge emitted more entries than the window holds");
`endif

endmodule

@@ rtl/tmwf_back.sv @@
// Back end: pops classified requests, runs the axis window updates, applies
// the spread test and drives the result register. Depends on tmwf_pkg,
// tmwf_if and tmwf_axis.
module tmwf_back #(
  parameter int unsigned DEPTH = tmwf_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tmwf_pkg::sample_t   max_spread,
  input  tmwf_pkg::q_status_t q_status,
  input  tmwf_pkg::entry_t    q_head,
  output logic                pop,
  tmwf_out_if.source          out_res
);
  import tmwf_pkg::*;

  back_state_t state_r;
  back_state_t state_nxt;
  op_t         op_r;
  cmd_t        cmd_r;
  sample_t     x_held_r;
  sample_t     y_held_r;
  logic        out_valid_r;
  cmd_t        out_cmd_r;
  sample_t     out_x_r;
  sample_t     out_y_r;

  logic    start_x;
  logic    start_y;
  logic    held_upd;
  logic    load;
  logic    out_free;
  rank_t   rank_x;
  rank_t   rank_y;
  rank_t   rank_sel;
  sample_t spread;
  sample_t mean;
  logic    pass;

  tmwf_axis #(.DEPTH(DEPTH)) u_x_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_x),
    .sample (q_head.sample),
    .rank   (rank_x)
  );

  tmwf_axis #(.DEPTH(DEPTH)) u_y_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_y),
    .sample (q_head.sample),
    .rank   (rank_y)
  );

  assign rank_sel = (op_r == OP_Y) ? rank_y : rank_x;
  assign spread   = rank_sel.hi - rank_sel.lo;
  assign pass     = (spread <= max_spread);
  assign mean     = rank_sel.sum[SUM_W-1 -: SAMPLE_W];
  assign out_free = !out_valid_r || out_res.ready;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    start_x   = 1'b0;
    start_y   = 1'b0;
    held_upd  = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          unique case (q_head.op)
            OP_X: begin
              start_x   = 1'b1;
              state_nxt = B_MERGE;
            end
            OP_Y: begin
              start_y   = 1'b1;
              state_nxt = B_MERGE;
            end
            default: begin
              state_nxt = B_EMIT;
            end
          endcase
        end
      end
      B_MERGE: begin
        if (rank_sel.done) begin
          state_nxt = B_FILTER;
        end
      end
      B_FILTER: begin
        held_upd  = 1'b1;
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        // hold here while the receiver stalls a previous result
        if (out_free) begin
          load      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      x_held_r    <= '0;
      y_held_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (held_upd && pass) begin
        if (op_r == OP_Y) begin
          y_held_r <= mean;
        end else begin
          x_held_r <= mean;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r  <= q_head.op;
      cmd_r <= q_head.cmd;
    end
    if (load) begin
      out_cmd_r <= cmd_r;
      out_x_r   <= x_held_r;
      out_y_r   <= y_held_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.next_command = out_cmd_r;
  assign out_res.x_position   = out_x_r;
  assign out_res.y_position   = out_y_r;

endmodule

@@ rtl/touch_xy_median_window_filter.sv @@
// Touch-screen X/Y position filter with a sliding sorted window per axis.
// Channels: in_req carries one 16-bit converter word per request; out_res
// returns one result per word: the next command byte and the held X and Y
// positions; cfg_wr writes max_spread and is always ready.
// Words cycle through four phases: phase 0 updates X, phase 2 updates Y,
// phases 1 and 3 only report. An updated axis takes the mean of window
// ranks DEPTH/2-2 to DEPTH/2+1 if their spread is within max_spread.
// An X or Y word passes the queue, the merge walk over the sorted window,
// the copy, the filter step and the result register; other words go from
// the queue straight to the result. The walk handles one entry per cycle,
// and the back end pops no new word until the last result is loaded.
// A two-entry request queue lets the input keep accepting while the back
// end works; the input stalls only when that queue is full.
// When the receiver stalls, the result register holds and the back end
// waits with the next result; the queue then fills and backs up the input.
// Reset (rst_n low, synchronous) clears the phase, both windows to zero,
// the held positions to zero and max_spread to 8.
// Depends on tmwf_pkg, tmwf_if, tmwf_front, tmwf_queue and tmwf_back.
module touch_xy_median_window_filter #(
  parameter int unsigned WINDOW_DEPTH = tmwf_pkg::WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tmwf_in_if.sink    in_req,
  tmwf_out_if.source out_res,
  tmwf_cfg_if.sink   cfg_wr
);
  import tmwf_pkg::*;

  sample_t   max_spread_r;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    q_head;
  q_status_t q_status;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_spread_r <= MAX_SPREAD_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      max_spread_r <= cfg_wr.max_spread;
    end
  end

  tmwf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  tmwf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .status     (q_status)
  );

  tmwf_back #(.DEPTH(WINDOW_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_spread (max_spread_r),
    .q_status   (q_status),
    .q_head     (q_head),
    .pop        (pop),
    .out_res    (out_res)
  );

endmodule
